// ----- hw/rtl/ray_convex_slab_clip_macros.svh -----
// Assertion helpers for the slab clipper.
`ifndef RAY_CONVEX_SLAB_CLIP_MACROS_SVH
`define RAY_CONVEX_SLAB_CLIP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RCSC_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("rcsc assertion failed");
// next-cycle implication
`define RCSC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("rcsc assertion failed");
`else
`define RCSC_ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define RCSC_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

// ----- hw/rtl/rcsc_pkg.sv -----
`timescale 1ns / 1ps
package rcsc_pkg;

    localparam int DATA_W   = 16;             // Q8.8 coordinate
    localparam int DIR_W    = 17;             // direction component
    localparam int PLANE_W  = 64;             // packed plane register
    localparam int CFG_REGS = 6;              // registers in the map
    localparam int IDX_W    = 3;              // config index width
    localparam int FACE_W   = 3;              // face index width
    localparam int NUM_W    = 34;             // signed plane distance
    localparam int DEN_W    = 34;             // signed direction dot
    localparam int AW       = NUM_W + 8;      // dividend magnitude
    localparam int DW       = DEN_W;          // divisor magnitude
    localparam int Q_BITS   = 16;             // quotient bits
    localparam int CW       = DW + Q_BITS;    // shifted divisor compare width
    localparam int LANE_LAT = 4 + Q_BITS;     // lane pipeline depth

    typedef struct packed {
        logic signed [DATA_W-1:0] p0_x;
        logic signed [DATA_W-1:0] p0_y;
        logic signed [DATA_W-1:0] p0_z;
        logic signed [DIR_W-1:0]  d_x;
        logic signed [DIR_W-1:0]  d_y;
        logic signed [DIR_W-1:0]  d_z;
    } ray_t;

    // clipping interval traveling down the cell row
    typedef struct packed {
        logic              valid;
        logic              reject;
        logic              face_set;
        logic [FACE_W-1:0] face;
        logic [Q_BITS-1:0] tmin;
        logic [Q_BITS-1:0] tmax;
    } tstate_t;

    typedef struct packed {
        logic den_zero;
        logic den_neg;
        logic num_neg;
    } lane_flag_t;

    typedef struct packed {
        lane_flag_t        flags;
        logic              ovf;
        logic              rem_nz;
        logic [Q_BITS-1:0] q;
    } lane_res_t;

endpackage

// ----- hw/rtl/rcsc_lane.sv -----
`timescale 1ns / 1ps
// Per-plane arithmetic: dot products, magnitudes, then a restoring
// divider one quotient bit per stage.
module rcsc_lane
    import rcsc_pkg::*;
(
    input  logic               clk,
    input  ray_t               ray,
    input  logic [PLANE_W-1:0] plane,
    output lane_res_t          res
);

    logic signed [DATA_W-1:0] n_vec [0:2];
    logic signed [DATA_W-1:0] p_vec [0:2];
    logic signed [DIR_W-1:0]  d_vec [0:2];
    logic signed [DATA_W-1:0] off;

    logic signed [31:0] pnp_reg [0:2];
    logic signed [32:0] pnd_reg [0:2];
    logic signed [DATA_W-1:0] off_reg;

    logic signed [NUM_W-1:0] num_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic signed [NUM_W-1:0] num_next;
    logic signed [DEN_W-1:0] den_next;

    logic [AW-1:0]  a_reg;
    logic [DW-1:0]  dm_reg;
    lane_flag_t     fl_reg;
    logic [NUM_W-1:0] num_mag;
    logic [DW-1:0]    den_mag;

    logic [AW-1:0]     r_reg   [0:Q_BITS];
    logic [DW-1:0]     dv_reg  [0:Q_BITS];
    logic [Q_BITS-1:0] q_reg   [0:Q_BITS];
    lane_flag_t        f_reg   [0:Q_BITS];
    logic              ovf_reg [0:Q_BITS];

    // unpack operands
    always_comb
    begin
        n_vec[0] = plane[15:0];
        n_vec[1] = plane[31:16];
        n_vec[2] = plane[47:32];
        off      = plane[63:48];
        p_vec[0] = ray.p0_x;
        p_vec[1] = ray.p0_y;
        p_vec[2] = ray.p0_z;
        d_vec[0] = ray.d_x;
        d_vec[1] = ray.d_y;
        d_vec[2] = ray.d_z;
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pnp_reg[k] <= 32'(n_vec[k]) * 32'(p_vec[k]);
            pnd_reg[k] <= 33'(n_vec[k]) * 33'(d_vec[k]);
        end
        off_reg <= off;
    end

    // stage 2: num = off - n.p0, den = n.d
    always_comb
    begin
        num_next = (NUM_W'(off_reg) <<< 8) - NUM_W'(pnp_reg[0])
                   - NUM_W'(pnp_reg[1]) - NUM_W'(pnp_reg[2]);
        den_next = DEN_W'(pnd_reg[0]) + DEN_W'(pnd_reg[1]) + DEN_W'(pnd_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
    end

    // stage 3: magnitudes and signs
    always_comb
    begin
        num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        den_mag = den_reg[DEN_W-1] ? DW'(-den_reg) : DW'(den_reg);
    end

    always_ff @(posedge clk)
    begin
        a_reg           <= AW'(num_mag) << 8;
        dm_reg          <= den_mag;
        fl_reg.den_zero <= (den_reg == '0);
        fl_reg.den_neg  <= den_reg[DEN_W-1];
        fl_reg.num_neg  <= num_reg[NUM_W-1];
    end

    // stage 4: quotient overflow check
    always_ff @(posedge clk)
    begin
        r_reg[0]   <= a_reg;
        dv_reg[0]  <= dm_reg;
        q_reg[0]   <= '0;
        f_reg[0]   <= fl_reg;
        ovf_reg[0] <= CW'(a_reg) >= (CW'(dm_reg) << Q_BITS);
    end

    // restoring divider, one bit per stage, MSB first
    for (genvar j = 1; j <= Q_BITS; j++)
    begin : g_div
        localparam int B = Q_BITS - j;
        logic [CW-1:0] shifted;
        logic          take;

        always_comb
        begin
            shifted = CW'(dv_reg[j-1]) << B;
            take    = CW'(r_reg[j-1]) >= shifted;
        end

        always_ff @(posedge clk)
        begin
            r_reg[j]   <= take ? (r_reg[j-1] - shifted[AW-1:0]) : r_reg[j-1];
            q_reg[j]   <= take ? (q_reg[j-1] | (Q_BITS'(1) << B)) : q_reg[j-1];
            dv_reg[j]  <= dv_reg[j-1];
            f_reg[j]   <= f_reg[j-1];
            ovf_reg[j] <= ovf_reg[j-1];
        end
    end

    assign res.flags  = f_reg[Q_BITS];
    assign res.ovf    = ovf_reg[Q_BITS];
    assign res.rem_nz = (r_reg[Q_BITS] != '0);
    assign res.q      = q_reg[Q_BITS];

endmodule

// ----- hw/rtl/rcsc_cell.sv -----
`timescale 1ns / 1ps
// One plane of the clipping row: forwards the ray, runs its lane and
// narrows the interval that arrives from the previous cell.
module rcsc_cell
    import rcsc_pkg::*;
#(
    parameter int FACE_ID = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ray_t               ray_in,
    input  logic [PLANE_W-1:0] plane,
    input  tstate_t            t_in,
    output ray_t               ray_out,
    output tstate_t            t_out
);

    lane_res_t res;
    ray_t      ray_reg;
    tstate_t   t_reg;
    tstate_t   t_next;

    rcsc_lane u_lane
    (
        .clk   (clk),
        .ray   (ray_in),
        .plane (plane),
        .res   (res)
    );

    // ray hops to the next cell every cycle
    always_ff @(posedge clk)
    begin
        ray_reg <= ray_in;
    end

    // interval update
    always_comb
    begin
        t_next = t_in;
        if (t_in.valid && !t_in.reject)
        begin
            if (res.flags.den_zero)
            begin
                if (res.flags.num_neg)
                    t_next.reject = 1'b1;
            end
            else if (res.flags.den_neg)
            begin
                // entering: tmin grows when the quotient exceeds it
                if (res.flags.num_neg && (res.ovf || res.q > t_in.tmin
                    || (res.q == t_in.tmin && res.rem_nz)))
                begin
                    t_next.tmin     = res.ovf ? '1 : res.q;
                    t_next.face     = FACE_W'(FACE_ID);
                    t_next.face_set = 1'b1;
                end
            end
            else
            begin
                // exiting: a negative quotient always rejects
                if (res.flags.num_neg)
                    t_next.reject = 1'b1;
                else if (!res.ovf && res.q < t_in.tmax)
                    t_next.tmax = res.q;
            end
            if (t_next.tmax < t_next.tmin)
                t_next.reject = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= '0;
        else
            t_reg <= t_next;
    end

    assign ray_out = ray_reg;
    assign t_out   = t_reg;

endmodule

// ----- hw/rtl/ray_convex_slab_clip.sv -----
`timescale 1ns / 1ps
// Pipeline: input register, 20-stage per-plane divider lane, one cell per plane,
//   output register.
// Throughput: one transaction per cycle; busy is never raised.
// Reset: rst_n clears plane registers to zero and all valid bits.
// The receiver cannot stall: done is a one-cycle strobe.
`include "ray_convex_slab_clip_macros.svh"
module ray_convex_slab_clip
    import rcsc_pkg::*;
#(
    parameter int N_FACES = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] ray_start_x,
    input  logic signed [DATA_W-1:0] ray_start_y,
    input  logic signed [DATA_W-1:0] ray_start_z,
    input  logic signed [DATA_W-1:0] ray_end_x,
    input  logic signed [DATA_W-1:0] ray_end_y,
    input  logic signed [DATA_W-1:0] ray_end_z,
    input  logic [DATA_W-1:0]        max_param,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [PLANE_W-1:0]       cfg_data,
    output logic                     done,
    output logic                     hit,
    output logic [Q_BITS-1:0]        hit_param,
    output logic [FACE_W-1:0]        hit_face
);

    logic [PLANE_W-1:0] plane_reg [0:N_FACES-1];
    ray_t               ray_reg;
    tstate_t            seed_reg  [0:LANE_LAT];
    ray_t               ray_chain [0:N_FACES-1];
    tstate_t            t_chain   [0:N_FACES];
    logic               done_reg;
    logic               hit_reg;
    logic [Q_BITS-1:0]  param_reg;
    logic [FACE_W-1:0]  face_reg;
    logic               hit_next;

    assign busy = 1'b0;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < N_FACES; p++)
                plane_reg[p] <= '0;
        end
        else
        begin
            for (int p = 0; p < N_FACES; p++)
                if (cfg_we && cfg_index == IDX_W'(p) && p < CFG_REGS)
                    plane_reg[p] <= cfg_data;
        end
    end

    // input register: start point and direction
    always_ff @(posedge clk)
    begin
        ray_reg.p0_x <= ray_start_x;
        ray_reg.p0_y <= ray_start_y;
        ray_reg.p0_z <= ray_start_z;
        ray_reg.d_x  <= DIR_W'(ray_end_x) - DIR_W'(ray_start_x);
        ray_reg.d_y  <= DIR_W'(ray_end_y) - DIR_W'(ray_start_y);
        ray_reg.d_z  <= DIR_W'(ray_end_z) - DIR_W'(ray_start_z);
    end

    // initial interval, delayed to meet the first cell's lane result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LANE_LAT; s++)
                seed_reg[s] <= '0;
        end
        else
        begin
            seed_reg[0].valid    <= start && !busy;
            seed_reg[0].reject   <= 1'b0;
            seed_reg[0].face_set <= 1'b0;
            seed_reg[0].face     <= '0;
            seed_reg[0].tmin     <= '0;
            seed_reg[0].tmax     <= max_param;
            for (int s = 1; s <= LANE_LAT; s++)
                seed_reg[s] <= seed_reg[s-1];
        end
    end

    assign ray_chain[0] = ray_reg;
    assign t_chain[0]   = seed_reg[LANE_LAT];

    // row of plane cells
    for (genvar i = 0; i < N_FACES; i++)
    begin : g_cell
        if (i < N_FACES - 1)
        begin : g_mid
            rcsc_cell #(.FACE_ID(i)) u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ray_in  (ray_chain[i]),
                .plane   (plane_reg[i]),
                .t_in    (t_chain[i]),
                .ray_out (ray_chain[i+1]),
                .t_out   (t_chain[i+1])
            );
        end
        else
        begin : g_last
            rcsc_cell #(.FACE_ID(i)) u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ray_in  (ray_chain[i]),
                .plane   (plane_reg[i]),
                .t_in    (t_chain[i]),
                .ray_out (),
                .t_out   (t_chain[i+1])
            );
        end
    end

    // result register
    assign hit_next = t_chain[N_FACES].valid && !t_chain[N_FACES].reject
                      && t_chain[N_FACES].face_set;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= t_chain[N_FACES].valid;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        param_reg <= hit_next ? t_chain[N_FACES].tmin : '0;
        face_reg  <= hit_next ? t_chain[N_FACES].face : '0;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign hit_param = param_reg;
    assign hit_face  = face_reg;

    `RCSC_ASSERT_IMPLY(a_miss_zero, clk, rst_n, done && !hit, hit_param == '0 && hit_face == '0)
    `RCSC_ASSERT_IMPLY(a_face_range, clk, rst_n, done && hit, 32'(hit_face) < N_FACES)
    `RCSC_ASSERT_NEXT(a_row_to_done, clk, rst_n, t_chain[N_FACES].valid, done)
    `RCSC_ASSERT_IMPLY(a_hit_strobe, clk, rst_n, hit, done)

endmodule
